[rtl/core/fdmc_pkg.sv]
package fdmc_pkg;

  localparam int MAX_WIDTH   = 640;
  localparam int MAX_HEIGHT  = 480;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CHAN_W  = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int THR_W   = 8;
  localparam int CNT_W   = 19;
  localparam int SUM_W   = 28;
  localparam int CFG_W   = 10;
  localparam int CFGI_W  = 2;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int GSUM_W  = 22;

  localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(640);
  localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);
  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(100);

  localparam logic [GSUM_W-1:0] W_RED   = GSUM_W'(4899);
  localparam logic [GSUM_W-1:0] W_GREEN = GSUM_W'(9617);
  localparam logic [GSUM_W-1:0] W_BLUE  = GSUM_W'(1868);
  localparam logic [GSUM_W-1:0] G_ROUND = GSUM_W'(8192);
  localparam int GREY_SHIFT = 14;

  typedef enum logic [CFGI_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_DIFF_THRESH  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_red;
    logic [CHAN_W-1:0] chan_green;
    logic [CHAN_W-1:0] chan_blue;
  } in_pix_t;

  typedef struct packed {
    logic [CNT_W-1:0] motion_count;
    logic [COL_W-1:0] centroid_x;
    logic [ROW_W-1:0] centroid_y;
    logic             found;
  } out_res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CHAN_W-1:0] grey;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
    logic              loaded;
  } pix_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } div_job_t;

  function automatic logic [CHAN_W-1:0] to_grey(input in_pix_t p);
    logic [GSUM_W-1:0] acc;
    acc = W_RED * GSUM_W'(p.chan_red) + W_GREEN * GSUM_W'(p.chan_green)
        + W_BLUE * GSUM_W'(p.chan_blue) + G_ROUND;
    return acc[GREY_SHIFT +: CHAN_W];
  endfunction

endpackage

[rtl/core/fdmc_front.sv]
module fdmc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fdmc_pkg::in_pix_t          in_data,
  input  logic [fdmc_pkg::COL_W-1:0] frame_width,
  input  logic [fdmc_pkg::ROW_W-1:0] frame_height,
  input  logic                       div_idle,
  input  logic                       job_pending,
  output logic                       s0_valid,
  output fdmc_pkg::pix_t             s0_pix
);
  import fdmc_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             loaded_r, loaded_nxt;
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             col_end, row_end, last, need_div;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = COL_W'(1);
    end else if (frame_width > COL_W'(MAX_WIDTH)) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (frame_height > ROW_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign col_end  = ({1'b0, col_r} + (COL_W+1)'(1)) >= {1'b0, w_eff};
  assign row_end  = ({1'b0, row_r} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
  assign last     = col_end && row_end;
  assign need_div = last && loaded_r;
  assign in_ready = !need_div || (div_idle && !job_pending);
  assign s0_valid = in_valid && in_ready;

  assign s0_pix.addr   = ADDR_W'(row_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_r);
  assign s0_pix.grey   = to_grey(in_data);
  assign s0_pix.col    = col_r;
  assign s0_pix.row    = row_r;
  assign s0_pix.last   = last;
  assign s0_pix.loaded = loaded_r;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    loaded_nxt = loaded_r;
    if (s0_valid) begin
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt    = '0;
          loaded_nxt = 1'b1;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      loaded_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      loaded_r <= loaded_nxt;
    end
  end

endmodule

[rtl/core/fdmc_store.sv]
module fdmc_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s0_valid,
  input  fdmc_pkg::pix_t             s0_pix,
  input  logic [fdmc_pkg::THR_W-1:0] diff_threshold,
  output logic                       job_valid,
  output fdmc_pkg::div_job_t         job
);
  import fdmc_pkg::*;

  logic [CHAN_W-1:0] mem [STORE_DEPTH];
  logic [CHAN_W-1:0] rd_q_r;
  logic              fwd_r;
  logic [CHAN_W-1:0] fwd_grey_r;
  logic              s1_valid_r;
  pix_t              s1_r;
  logic [CNT_W-1:0]  hit_r, hit_nxt;
  logic [SUM_W-1:0]  sx_r, sx_nxt;
  logic [SUM_W-1:0]  sy_r, sy_nxt;
  logic [CHAN_W-1:0] old_grey, diff;
  logic              hit;
  logic [CNT_W-1:0]  hit_sum;
  logic [SUM_W-1:0]  sx_sum, sy_sum;

  always_ff @(posedge clk) begin
    if (s0_valid) begin
      rd_q_r <= mem[s0_pix.addr];
    end
    if (s1_valid_r) begin
      mem[s1_r.addr] <= s1_r.grey;
    end
  end

  // forward the value being written when the next read hits the same entry
  always_ff @(posedge clk) begin
    if (s0_valid) begin
      fwd_r      <= s1_valid_r && (s1_r.addr == s0_pix.addr);
      fwd_grey_r <= s1_r.grey;
      s1_r       <= s0_pix;
    end
  end

  assign old_grey = fwd_r ? fwd_grey_r : rd_q_r;
  assign diff     = (s1_r.grey > old_grey) ? (s1_r.grey - old_grey) : (old_grey - s1_r.grey);
  assign hit      = s1_r.loaded && (diff > diff_threshold);

  assign hit_sum = hit ? hit_r + CNT_W'(1) : hit_r;
  assign sx_sum  = hit ? sx_r + SUM_W'(s1_r.col) : sx_r;
  assign sy_sum  = hit ? sy_r + SUM_W'(s1_r.row) : sy_r;

  assign job_valid = s1_valid_r && s1_r.last && s1_r.loaded;
  assign job.count = hit_sum;
  assign job.sum_x = sx_sum;
  assign job.sum_y = sy_sum;

  always_comb begin
    hit_nxt = hit_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    if (s1_valid_r) begin
      if (s1_r.last) begin
        hit_nxt = '0;
        sx_nxt  = '0;
        sy_nxt  = '0;
      end else begin
        hit_nxt = hit_sum;
        sx_nxt  = sx_sum;
        sy_nxt  = sy_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      hit_r      <= '0;
      sx_r       <= '0;
      sy_r       <= '0;
    end else begin
      s1_valid_r <= s0_valid;
      hit_r      <= hit_nxt;
      sx_r       <= sx_nxt;
      sy_r       <= sy_nxt;
    end
  end

endmodule

[rtl/core/fdmc_div.sv]
module fdmc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  fdmc_pkg::div_job_t    job,
  output logic                  idle,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fdmc_pkg::out_res_t    out_data
);
  import fdmc_pkg::*;

  div_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [SUM_W-1:0]  qx_r, qx_nxt, qy_r, qy_nxt;
  logic [CNT_W-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  logic [CNT_W:0]    rx_sh, ry_sh;
  logic              gex, gey, last_step, found;

  assign last_step = step_r == STEP_W'(SUM_W - 1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DIV_IDLE: if (start) state_nxt = DIV_RUN;
      DIV_RUN:  if (last_step) state_nxt = DIV_DONE;
      DIV_DONE: if (out_ready) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    idle      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      DIV_IDLE: idle = 1'b1;
      DIV_DONE: out_valid = 1'b1;
      default: begin
        idle      = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  assign rx_sh = {rx_r, qx_r[SUM_W-1]};
  assign ry_sh = {ry_r, qy_r[SUM_W-1]};
  assign gex   = rx_sh >= {1'b0, den_r};
  assign gey   = ry_sh >= {1'b0, den_r};

  always_comb begin
    step_nxt = step_r;
    den_nxt  = den_r;
    qx_nxt   = qx_r;
    qy_nxt   = qy_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    if (state_r == DIV_IDLE && start) begin
      step_nxt = '0;
      den_nxt  = job.count;
      qx_nxt   = job.sum_x;
      qy_nxt   = job.sum_y;
      rx_nxt   = '0;
      ry_nxt   = '0;
    end else if (state_r == DIV_RUN) begin
      step_nxt = step_r + STEP_W'(1);
      qx_nxt   = {qx_r[SUM_W-2:0], gex};
      qy_nxt   = {qy_r[SUM_W-2:0], gey};
      rx_nxt   = gex ? CNT_W'(rx_sh - {1'b0, den_r}) : CNT_W'(rx_sh);
      ry_nxt   = gey ? CNT_W'(ry_sh - {1'b0, den_r}) : CNT_W'(ry_sh);
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    den_r  <= den_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign found                 = den_r != '0;
  assign out_data.motion_count = den_r;
  assign out_data.centroid_x   = found ? qx_r[COL_W-1:0] : '0;
  assign out_data.centroid_y   = found ? qy_r[ROW_W-1:0] : '0;
  assign out_data.found        = found;

endmodule

[rtl/core/frame_difference_motion_centroid.sv]
// Frame-difference motion centroid. Pixels are taken one per clock in raster order,
// turned to grey and compared against the previous frame held in a 307200 x 8
// simple dual-port store (read in the accept cycle, compare and write back in the cycle
// after, with forwarding when both hit the same entry). The first frame after reset only
// loads the store and produces no result; the store is not cleared. Every later frame
// offers its result after its last pixel is transferred in: a shared serial divider forms
// both mean coordinates, one quotient bit per cycle. The input holds off only on the last
// pixel of a frame while the divider is busy or its result has not been transferred yet,
// so frames of 31 pixels or more stream at one per clock when the result is taken at once.
module frame_difference_motion_centroid (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fdmc_pkg::in_pix_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fdmc_pkg::out_res_t          out_data,
  input  logic                        cfg_we,
  input  logic [fdmc_pkg::CFGI_W-1:0] cfg_index,
  input  logic [fdmc_pkg::CFG_W-1:0]  cfg_wdata
);
  import fdmc_pkg::*;

  logic [COL_W-1:0] frame_width_r;
  logic [ROW_W-1:0] frame_height_r;
  logic [THR_W-1:0] diff_threshold_r;
  logic             s0_valid;
  pix_t             s0_pix;
  logic             div_idle;
  logic             job_valid;
  div_job_t         job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= WIDTH_RESET;
      frame_height_r   <= HEIGHT_RESET;
      diff_threshold_r <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r    <= cfg_wdata[COL_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r   <= cfg_wdata[ROW_W-1:0];
        CFG_DIFF_THRESH:  diff_threshold_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  fdmc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .div_idle     (div_idle),
    .job_pending  (job_valid),
    .s0_valid     (s0_valid),
    .s0_pix       (s0_pix)
  );

  fdmc_store u_store (
    .clk            (clk),
    .rst_n          (rst_n),
    .s0_valid       (s0_valid),
    .s0_pix         (s0_pix),
    .diff_threshold (diff_threshold_r),
    .job_valid      (job_valid),
    .job            (job)
  );

  fdmc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (job_valid),
    .job       (job),
    .idle      (div_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/core/fdmc_checker.sv]
module fdmc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input fdmc_pkg::in_pix_t           in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input fdmc_pkg::out_res_t          out_data
);
  import fdmc_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("pixel dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.found == (out_data.motion_count != '0))
    else $error("found disagrees with motion count");

  a_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.centroid_x == '0 && out_data.centroid_y == '0)
    else $error("centroid not zero without motion");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.centroid_x < COL_W'(MAX_WIDTH)
               && out_data.centroid_y < ROW_W'(MAX_HEIGHT))
    else $error("centroid outside frame");

endmodule

bind frame_difference_motion_centroid fdmc_checker u_fdmc_checker (.*);

[tb/tb.sv]
module tb;
  import fdmc_pkg::*;

  localparam int LOAD_ROWS    = 4;
  localparam int NARROW_W     = 40;
  localparam int RANDOM_ITEMS = 380;
  localparam int IDLE_PCT     = 19;
  localparam int DRAIN_CYCLES = 64;

  typedef enum int {
    PIX_NOISE,
    PIX_STILL,
    PIX_SPARSE
  } scene_t;

  class centroid_predictor;
    bit [CHAN_W-1:0]  grey_store [STORE_DEPTH];
    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [THR_W-1:0] thr_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      hit_count;
    int unsigned      col_sum;
    int unsigned      row_sum;
    bit               loaded;
    out_res_t         pending_results[$];
    int               mismatches;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      thr_reg    = THR_RESET;
      col_pos    = 0;
      row_pos    = 0;
      hit_count  = 0;
      col_sum    = 0;
      row_sum    = 0;
      loaded     = 0;
      mismatches = 0;
    endfunction

    function void write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg  = value[COL_W-1:0];
        CFG_FRAME_HEIGHT: height_reg = value[ROW_W-1:0];
        CFG_DIFF_THRESH:  thr_reg    = value[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function bit [CHAN_W-1:0] grey_of(input in_pix_t p);
      int unsigned acc;
      acc = 4899 * p.chan_red + 9617 * p.chan_green + 1868 * p.chan_blue + 8192;
      return CHAN_W'(acc >> 14);
    endfunction

    function bit [CHAN_W-1:0] grey_here();
      return grey_store[row_pos * MAX_WIDTH + col_pos];
    endfunction

    function bit at_frame_start();
      return (col_pos == 0) && (row_pos == 0);
    endfunction

    function void take_pixel(input in_pix_t p);
      int unsigned w;
      int unsigned h;
      int unsigned addr;
      int unsigned g;
      int unsigned old;
      int unsigned diff;
      out_res_t    res;
      w    = clamp_dim(width_reg, MAX_WIDTH);
      h    = clamp_dim(height_reg, MAX_HEIGHT);
      g    = grey_of(p);
      addr = row_pos * MAX_WIDTH + col_pos;
      if (addr < STORE_DEPTH) begin
        if (loaded) begin
          old  = grey_store[addr];
          diff = (g > old) ? g - old : old - g;
          if (diff > thr_reg) begin
            hit_count = (hit_count + 1) & 32'h7FFFF;
            col_sum   = (col_sum + col_pos) & 32'hFFFFFFF;
            row_sum   = (row_sum + row_pos) & 32'hFFFFFFF;
          end
        end
        grey_store[addr] = CHAN_W'(g);
      end
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          row_pos = 0;
          if (loaded) begin
            res.motion_count = hit_count[CNT_W-1:0];
            res.centroid_x   = '0;
            res.centroid_y   = '0;
            res.found        = 1'b0;
            if (hit_count != 0) begin
              res.centroid_x = COL_W'(col_sum / hit_count);
              res.centroid_y = ROW_W'(row_sum / hit_count);
              res.found      = 1'b1;
            end
            pending_results.push_back(res);
          end
          loaded    = 1;
          hit_count = 0;
          col_sum   = 0;
          row_sum   = 0;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    endfunction

    task log_mismatch(input string what, input int unsigned got, input int unsigned want);
      $display("%0t: %s got %0d, want %0d", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(input out_res_t got);
      out_res_t want;
      if (pending_results.size() == 0) begin
        log_mismatch("result with none pending, motion_count", got.motion_count, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.motion_count !== want.motion_count)
          log_mismatch("motion_count", got.motion_count, want.motion_count);
        if (got.centroid_x !== want.centroid_x)
          log_mismatch("centroid_x", got.centroid_x, want.centroid_x);
        if (got.centroid_y !== want.centroid_y)
          log_mismatch("centroid_y", got.centroid_y, want.centroid_y);
        if (got.found !== want.found)
          log_mismatch("found", got.found, want.found);
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_pix_t             in_data;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_res_t            out_data;
  logic                cfg_we;
  logic [CFGI_W-1:0]   cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;

  centroid_predictor centroid_calc = new();
  int pixels_sent   = 0;
  int in_idle_pct   = IDLE_PCT;
  int out_stall_pct = IDLE_PCT;

  frame_difference_motion_centroid uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAIL frame_difference_motion_centroid");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) centroid_calc.check_result(out_data);
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  function automatic in_pix_t grey_pixel(input logic [CHAN_W-1:0] v);
    return '{v, v, v};
  endfunction

  function automatic in_pix_t make_pixel(input scene_t scene);
    in_pix_t p;
    bit      still;
    p.chan_red   = $urandom_range(255);
    p.chan_green = $urandom_range(255);
    p.chan_blue  = $urandom_range(255);
    case (scene)
      PIX_STILL:  still = 1'b1;
      PIX_SPARSE: still = ($urandom_range(11) != 0);
      default:    still = 1'b0;
    endcase
    if (still) p = grey_pixel(centroid_calc.grey_here());
    return p;
  endfunction

  task automatic send_pixel(input in_pix_t p);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    centroid_calc.take_pixel(p);
    pixels_sent++;
  endtask

  task automatic send_frame(input scene_t scene);
    do send_pixel(make_pixel(scene)); while (!centroid_calc.at_frame_start());
  endtask

  // hold off until every transfer is checked and the divider has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (centroid_calc.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_index_t idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    centroid_calc.write_reg(idx, CFG_W'(value));
    @(posedge clk);
  endtask

  task automatic pick_frame_size();
    int unsigned sel;
    int unsigned w;
    sel = $urandom_range(9);
    if (sel == 0)      w = 0;
    else if (sel <= 6) w = $urandom_range(1, 8);
    else if (sel <= 8) w = $urandom_range(9, 40);
    else               w = $urandom_range(41, 120);
    write_cfg(CFG_FRAME_WIDTH, w);
    write_cfg(CFG_FRAME_HEIGHT, (w > 40) ? $urandom_range(0, 1) : $urandom_range(0, LOAD_ROWS));
  endtask

  task automatic pick_threshold();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0)      write_cfg(CFG_DIFF_THRESH, 0);
    else if (sel == 1) write_cfg(CFG_DIFF_THRESH, 255);
    else if (sel <= 4) write_cfg(CFG_DIFF_THRESH, $urandom_range(0, 60));
    else               write_cfg(CFG_DIFF_THRESH, $urandom_range(0, 255));
  endtask

  initial begin
    int     random_start;
    int     done;
    scene_t scene;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the store over the widest area any later frame touches
    write_cfg(CFG_FRAME_WIDTH, $urandom_range(MAX_WIDTH, 1023));
    write_cfg(CFG_FRAME_HEIGHT, LOAD_ROWS);
    repeat (MAX_WIDTH) send_pixel(make_pixel(PIX_NOISE));
    wait_idle();
    write_cfg(CFG_FRAME_WIDTH, NARROW_W);
    send_frame(PIX_NOISE);

    wait_idle();
    write_cfg(CFG_FRAME_WIDTH, 1);
    write_cfg(CFG_FRAME_HEIGHT, 1);
    write_cfg(CFG_DIFF_THRESH, 0);
    send_pixel(grey_pixel(8'h00));
    send_pixel(grey_pixel(8'hFF));
    send_pixel(grey_pixel(8'hFF));
    send_pixel('{8'hFF, 8'h00, 8'h00});
    send_pixel('{8'h00, 8'hFF, 8'h00});
    send_pixel('{8'h00, 8'h00, 8'hFF});

    wait_idle();
    write_cfg(CFG_DIFF_THRESH, 255);
    send_pixel(grey_pixel(8'h00));
    send_pixel(grey_pixel(8'hFF));

    wait_idle();
    write_cfg(CFG_DIFF_THRESH, 50);
    send_pixel(grey_pixel(8'd0));
    send_pixel(grey_pixel(8'd50));
    send_pixel(grey_pixel(8'd101));
    send_pixel(grey_pixel(8'd101));

    wait_idle();
    write_cfg(CFG_FRAME_WIDTH, 0);
    write_cfg(CFG_FRAME_HEIGHT, 0);
    write_cfg(CFG_DIFF_THRESH, 0);
    send_pixel(grey_pixel(8'd7));
    send_pixel(grey_pixel(8'd9));

    // shrink the width while the column sits past the new limit
    wait_idle();
    write_cfg(CFG_FRAME_WIDTH, 6);
    write_cfg(CFG_FRAME_HEIGHT, 2);
    write_cfg(CFG_DIFF_THRESH, 20);
    repeat (4) send_pixel(make_pixel(PIX_NOISE));
    wait_idle();
    write_cfg(CFG_FRAME_WIDTH, 2);
    send_frame(PIX_NOISE);

    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_ITEMS) begin
      done          = pixels_sent - random_start;
      in_idle_pct   = (done >= 130 && done < 250) ? 0 : IDLE_PCT;
      out_stall_pct = in_idle_pct;
      wait_idle();
      pick_frame_size();
      if ($urandom_range(1) != 0) pick_threshold();
      repeat ($urandom_range(1, 4)) begin
        scene = scene_t'($urandom_range(0, 2));
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 3)) send_pixel(make_pixel(scene));
          wait_idle();
          write_cfg(CFG_FRAME_WIDTH, $urandom_range(0, 16));
        end
        send_frame(scene);
      end
    end

    in_idle_pct   = IDLE_PCT;
    out_stall_pct = IDLE_PCT;
    wait_idle();
    if (centroid_calc.mismatches == 0)
      $display("PASS frame_difference_motion_centroid");
    else
      $display("FAIL frame_difference_motion_centroid");
    $finish;
  end

endmodule
